// ===== sv/assert_macros.svh =====
// Assertion helpers included by the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every rising edge of the clock, ignored while reset is high.
`define ASSERT_CLK(label, clock, reset, prop, msg) \
  label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// Checked at every rising edge of the clock, reset included.
`define ASSERT_ALWAYS(label, clock, prop, msg) \
  label: assert property (@(posedge clock) (prop)) else $error(msg);

`endif

// ===== sv/bfa_pkg.sv =====
package bfa_pkg;

  localparam int MAX_FRAMES  = 4096;
  localparam int WORD_BITS   = 32;
  localparam int MAP_WORDS   = MAX_FRAMES / WORD_BITS;
  localparam int WORD_IDX_W  = $clog2(MAP_WORDS);
  localparam int WORD_CNT_W  = WORD_IDX_W + 1;
  localparam int BIT_IDX_W   = $clog2(WORD_BITS);
  localparam int FRAME_IDX_W = $clog2(MAX_FRAMES);
  localparam int COUNT_W     = 13;
  localparam int PAGE_SHIFT  = 12;
  localparam int FRAME_NUM_W = 20;
  localparam int ADDR_W      = 32;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 20;

  // Request codes.
  localparam logic [1:0] REQ_ALLOC = 2'd0;
  localparam logic [1:0] REQ_FREE  = 2'd1;
  localparam logic [1:0] REQ_INIT  = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] CFG_REGION_FIRST  = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_REGION_FRAMES = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_RESERVED      = 2'd2;

  typedef struct packed {
    logic [1:0]        req_type;
    logic [ADDR_W-1:0] frame_addr;
  } req_t;

  typedef struct packed {
    logic               ok;
    logic [ADDR_W-1:0]  alloc_addr;
    logic [COUNT_W-1:0] used_count;
    logic [COUNT_W-1:0] free_count;
  } rsp_t;

  typedef struct packed {
    logic                 found;
    logic [BIT_IDX_W-1:0] bit_idx;
  } ffz_t;

  // Mask of the low bits of a map word that lie below a frame limit, where
  // rem is the limit minus the first frame of the word.
  function automatic logic [WORD_BITS-1:0] low_mask(input logic [COUNT_W-1:0] rem);
    logic [WORD_BITS-1:0] m;
    m = '1;
    if (rem < COUNT_W'(WORD_BITS)) begin
      m = ~({WORD_BITS{1'b1}} << rem[BIT_IDX_W-1:0]);
    end
    return m;
  endfunction

endpackage

// ===== sv/bfa_ram.sv =====
module bfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 128
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/bfa_ffz.sv =====
// Finds the lowest free frame of one map word, counting frames at or beyond
// the region limit as used.
module bfa_ffz (
  input  logic [bfa_pkg::WORD_BITS-1:0]  word,
  input  logic [bfa_pkg::WORD_IDX_W-1:0] word_idx,
  input  logic [bfa_pkg::COUNT_W-1:0]    limit,
  output bfa_pkg::ffz_t                  res
);

  logic [bfa_pkg::COUNT_W-1:0]   base;
  logic [bfa_pkg::WORD_BITS-1:0] cand;

  assign base = bfa_pkg::COUNT_W'({word_idx, bfa_pkg::BIT_IDX_W'(0)});

  always_comb begin
    cand = '0;
    if (limit > base) begin
      cand = ~word & bfa_pkg::low_mask(limit - base);
    end
    res = '0;
    for (int i = bfa_pkg::WORD_BITS - 1; i >= 0; i--) begin
      if (cand[i]) begin
        res.found   = 1'b1;
        res.bit_idx = bfa_pkg::BIT_IDX_W'(i);
      end
    end
  end

endmodule

// ===== sv/bitmap_frame_allocator.sv =====
// First-fit physical page-frame allocator over a used/free bitmap.
// A request beat is taken at a rising edge with start high and busy low;
// req.req_type selects allocate, free or map initialization. Each request
// gives exactly one result beat: done is high for one cycle with rsp valid,
// and the receiver cannot stall it, so nothing waits on the output side.
// Configuration beats on cfg_valid/cfg_ready are always taken (cfg_ready is
// tied high) and must only be sent while the block is idle.
// Steps, from the accepting edge to the edge that takes the result:
//   allocate: reads the map words in order until a free frame is found
//             or the region ends; answered straight from idle when empty;
//   free: reads the target word, then clears its bit if set; init: writes
//   the reserved words in turn; ignored frees, unused request codes and an init with none reserved: straight from idle.
// busy drops in the cycle that shows the result, so the next request can be
// taken at the edge that takes it. The allocate scan walks the single read
// port of the bitmap RAM one word a cycle, and initialization sweeps its
// single write port the same way.
// Reset clears a valid flag per map word, so every frame reads as free
// without a clearing pass; the configuration returns to its reset values
// and the used count to zero.
`include "assert_macros.svh"

module bitmap_frame_allocator (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  bfa_pkg::req_t                     req,
  output logic                              done,
  output bfa_pkg::rsp_t                     rsp,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bfa_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [bfa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FREE_RD,
    ST_FREE_CHK,
    ST_INIT
  } state_t;

  state_t state;

  // Configuration registers.
  logic [bfa_pkg::FRAME_NUM_W-1:0] region_first_frame;
  logic [bfa_pkg::COUNT_W-1:0]     region_frames;
  logic [bfa_pkg::COUNT_W-1:0]     reserved_frames;

  // Control and bookkeeping.
  logic [bfa_pkg::WORD_CNT_W-1:0] rd_cnt;
  logic                           issued;
  logic [bfa_pkg::WORD_IDX_W-1:0] word_q;
  logic [bfa_pkg::BIT_IDX_W-1:0]  bit_q;
  logic [bfa_pkg::COUNT_W-1:0]    used_total;
  logic [bfa_pkg::MAP_WORDS-1:0]  vld;

  // Derived values.
  logic [bfa_pkg::COUNT_W-1:0]     eff_frames;
  logic [bfa_pkg::COUNT_W-1:0]     resv_eff;
  logic [bfa_pkg::WORD_CNT_W-1:0]  n_words;
  logic [bfa_pkg::WORD_CNT_W-1:0]  resv_words;
  logic [bfa_pkg::FRAME_NUM_W-1:0] frame_num;
  logic [bfa_pkg::FRAME_NUM_W-1:0] frame_off;
  logic                            free_hit;
  logic [bfa_pkg::COUNT_W-1:0]     used_dec;
  logic [bfa_pkg::FRAME_NUM_W-1:0] alloc_frame;

  // Bitmap RAM ports.
  logic                           ram_we;
  logic [bfa_pkg::WORD_IDX_W-1:0] ram_waddr;
  logic [bfa_pkg::WORD_BITS-1:0]  ram_wdata;
  logic [bfa_pkg::WORD_IDX_W-1:0] ram_raddr;
  logic [bfa_pkg::WORD_BITS-1:0]  ram_rdata;
  logic [bfa_pkg::WORD_BITS-1:0]  rword;
  logic [bfa_pkg::COUNT_W-1:0]    init_rem;

  bfa_pkg::ffz_t ffz;

  // Builds a result beat; the free count saturates at zero when the region
  // was shrunk below the used count without a fresh initialization.
  function automatic bfa_pkg::rsp_t make_rsp(
    input logic                          ok,
    input logic [bfa_pkg::ADDR_W-1:0]    addr,
    input logic [bfa_pkg::COUNT_W-1:0]   used,
    input logic [bfa_pkg::COUNT_W-1:0]   frames
  );
    bfa_pkg::rsp_t r;
    r.ok         = ok;
    r.alloc_addr = addr;
    r.used_count = used;
    r.free_count = (frames > used) ? frames - used : '0;
    return r;
  endfunction

  assign busy      = (state != ST_IDLE);
  assign cfg_ready = 1'b1;

  // The managed region never extends past the map, and init never reserves
  // more frames than the region holds.
  assign eff_frames = (region_frames > bfa_pkg::COUNT_W'(bfa_pkg::MAX_FRAMES)) ?
                      bfa_pkg::COUNT_W'(bfa_pkg::MAX_FRAMES) : region_frames;
  assign resv_eff   = (reserved_frames > eff_frames) ? eff_frames : reserved_frames;

  always_comb begin
    logic [bfa_pkg::COUNT_W:0] nsum;
    logic [bfa_pkg::COUNT_W:0] rsum;
    nsum       = {1'b0, eff_frames} + (bfa_pkg::COUNT_W + 1)'(bfa_pkg::WORD_BITS - 1);
    rsum       = {1'b0, resv_eff} + (bfa_pkg::COUNT_W + 1)'(bfa_pkg::WORD_BITS - 1);
    n_words    = nsum[bfa_pkg::BIT_IDX_W +: bfa_pkg::WORD_CNT_W];
    resv_words = rsum[bfa_pkg::BIT_IDX_W +: bfa_pkg::WORD_CNT_W];
  end

  // A free names a frame by byte address; zero and addresses outside the
  // region are ignored.
  assign frame_num = req.frame_addr[bfa_pkg::ADDR_W-1:bfa_pkg::PAGE_SHIFT];
  assign frame_off = frame_num - region_first_frame;
  assign free_hit  = (req.frame_addr != '0) && (frame_num >= region_first_frame) &&
                     (frame_off < bfa_pkg::FRAME_NUM_W'(eff_frames));

  assign used_dec = (used_total != '0) ? used_total - 1'b1 : used_total;

  // Byte address of the allocated frame wraps at 32 bits.
  assign alloc_frame = region_first_frame +
                       bfa_pkg::FRAME_NUM_W'({word_q, ffz.bit_idx});

  // A word that has not been written since reset or init reads as all free.
  assign rword = vld[word_q] ? ram_rdata : '0;

  assign init_rem = resv_eff -
                    bfa_pkg::COUNT_W'({rd_cnt[bfa_pkg::WORD_IDX_W-1:0],
                                       bfa_pkg::BIT_IDX_W'(0)});

  // The scan streams reads from rd_cnt; free reads the word it targets.
  assign ram_raddr = (state == ST_SCAN) ? rd_cnt[bfa_pkg::WORD_IDX_W-1:0] : word_q;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = word_q;
    ram_wdata = rword | (bfa_pkg::WORD_BITS'(1) << ffz.bit_idx);
    unique case (state)
      ST_SCAN: begin
        ram_we = issued && ffz.found;
      end
      ST_FREE_CHK: begin
        ram_we    = rword[bit_q];
        ram_wdata = rword & ~(bfa_pkg::WORD_BITS'(1) << bit_q);
      end
      ST_INIT: begin
        ram_we    = 1'b1;
        ram_waddr = rd_cnt[bfa_pkg::WORD_IDX_W-1:0];
        ram_wdata = bfa_pkg::low_mask(init_rem);
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  bfa_ram #(
    .WIDTH(bfa_pkg::WORD_BITS),
    .DEPTH(bfa_pkg::MAP_WORDS)
  ) u_map (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  bfa_ffz u_ffz (
    .word    (rword),
    .word_idx(word_q),
    .limit   (eff_frames),
    .res     (ffz)
  );

  // Configuration writes; indexes beyond the list are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      region_first_frame <= '0;
      region_frames      <= bfa_pkg::COUNT_W'(4096);
      reserved_frames    <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        bfa_pkg::CFG_REGION_FIRST:  region_first_frame <= cfg_data;
        bfa_pkg::CFG_REGION_FRAMES: region_frames <= cfg_data[bfa_pkg::COUNT_W-1:0];
        bfa_pkg::CFG_RESERVED:      reserved_frames <= cfg_data[bfa_pkg::COUNT_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Request sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      done       <= 1'b0;
      issued     <= 1'b0;
      rd_cnt     <= '0;
      used_total <= '0;
      vld        <= '0;
    end else begin
      done <= 1'b0;
      if (ram_we) begin
        vld[ram_waddr] <= 1'b1;
      end
      unique case (state)
        ST_IDLE: begin
          if (start) begin
            rd_cnt <= '0;
            issued <= 1'b0;
            unique case (req.req_type)
              bfa_pkg::REQ_ALLOC: begin
                if (n_words == '0) begin
                  done <= 1'b1;
                  rsp  <= make_rsp(1'b0, '0, used_total, eff_frames);
                end else begin
                  state <= ST_SCAN;
                end
              end
              bfa_pkg::REQ_FREE: begin
                if (free_hit) begin
                  word_q <= frame_off[bfa_pkg::FRAME_IDX_W-1:bfa_pkg::BIT_IDX_W];
                  bit_q  <= frame_off[bfa_pkg::BIT_IDX_W-1:0];
                  state  <= ST_FREE_RD;
                end else begin
                  done <= 1'b1;
                  rsp  <= make_rsp(1'b0, '0, used_total, eff_frames);
                end
              end
              bfa_pkg::REQ_INIT: begin
                // Dropping every valid flag clears the whole map at once;
                // the sweep then writes only the reserved words.
                vld <= '0;
                if (resv_words == '0) begin
                  used_total <= '0;
                  done       <= 1'b1;
                  rsp        <= make_rsp(1'b1, '0, '0, eff_frames);
                end else begin
                  state <= ST_INIT;
                end
              end
              default: begin
                done <= 1'b1;
                rsp  <= make_rsp(1'b0, '0, used_total, eff_frames);
              end
            endcase
          end
        end
        ST_SCAN: begin
          // Reads are issued one word a cycle; the word read last cycle is
          // examined while the next read is in flight.
          priority if (issued && ffz.found) begin
            used_total <= used_total + 1'b1;
            done       <= 1'b1;
            rsp        <= make_rsp(1'b1, {alloc_frame, bfa_pkg::PAGE_SHIFT'(0)},
                                   used_total + 1'b1, eff_frames);
            state      <= ST_IDLE;
          end else if (issued && ({1'b0, word_q} == n_words - 1'b1)) begin
            done  <= 1'b1;
            rsp   <= make_rsp(1'b0, '0, used_total, eff_frames);
            state <= ST_IDLE;
          end else if (rd_cnt < n_words) begin
            issued <= 1'b1;
            word_q <= rd_cnt[bfa_pkg::WORD_IDX_W-1:0];
            rd_cnt <= rd_cnt + 1'b1;
          end else begin
            issued <= 1'b0;
          end
        end
        ST_FREE_RD: begin
          state <= ST_FREE_CHK;
        end
        ST_FREE_CHK: begin
          // A double free is accepted but leaves the count alone.
          done  <= 1'b1;
          state <= ST_IDLE;
          if (rword[bit_q]) begin
            used_total <= used_dec;
            rsp        <= make_rsp(1'b1, '0, used_dec, eff_frames);
          end else begin
            rsp <= make_rsp(1'b1, '0, used_total, eff_frames);
          end
        end
        ST_INIT: begin
          if (rd_cnt == resv_words - 1'b1) begin
            used_total <= resv_eff;
            done       <= 1'b1;
            rsp        <= make_rsp(1'b1, '0, resv_eff, eff_frames);
            state      <= ST_IDLE;
          end else begin
            rd_cnt <= rd_cnt + 1'b1;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  `ASSERT_CLK(a_accept_progress, clk, rst, (start && !busy) |=> (busy || done), "accepted request neither in progress nor answered")
  `ASSERT_CLK(a_done_idle, clk, rst, done |-> !busy, "result shown while a request is still in progress")
  `ASSERT_CLK(a_scan_bound, clk, rst, (state == ST_SCAN && issued) |-> ({1'b0, word_q} < n_words), "scan examined a word past the region")
  `ASSERT_CLK(a_used_bound, clk, rst, used_total <= bfa_pkg::COUNT_W'(bfa_pkg::MAX_FRAMES), "used count exceeds map size")
  `ASSERT_CLK(a_fail_addr, clk, rst, (done && !rsp.ok) |-> (rsp.alloc_addr == '0), "failed request reports an address")

endmodule
